// File: sv/blem_pkg.sv
// ----------------------------------------------------------------------------
// blem_pkg: shared types and constants for the bounded extract-min unit
// Data width, default capacity, status codes and the command struct that is
// broadcast to every cell of the sorted chain.
// ----------------------------------------------------------------------------
package blem_pkg;

   localparam int DataW       = 32;
   localparam int DefCapacity = 16;
   localparam int CountOutW   = 5;

   // Request opcodes
   typedef enum logic {
      OP_APPEND = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   // Response status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Command broadcast to all cells of the chain
   typedef struct packed {
      logic                    insert;
      logic                    extract;
      logic signed [DataW-1:0] value;
   } cell_cmd_type;

endpackage

// File: sv/bounded_list_extract_min_unit.sv
// Latency: a request's response is valid in the cycle after it is accepted.
// Throughput: one request per cycle while the response side does not stall;
// each request is a single parallel compare of the broadcast value in every cell.
// Reset: clears the entry count and the response valid; cell contents are not
// cleared since slots beyond the count are never read.
// ----------------------------------------------------------------------------
// bounded_list_extract_min_unit: bounded priority queue, append / remove-min
// Values are kept sorted ascending in a chain of cells, so the minimum is
// always in the first cell and removal shifts the chain one slot left.
// ----------------------------------------------------------------------------
module bounded_list_extract_min_unit
   import blem_pkg::*;
#(
   parameter int CAPACITY = DefCapacity
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_op,
   input  logic signed [DataW-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic signed [DataW-1:0] rsp_removed_value,
   output logic [CountOutW-1:0]    rsp_entry_count
);

   localparam int CntW = $clog2(CAPACITY + 1);

   logic                    req_accept;
   logic                    is_full;
   logic                    is_empty;
   cell_cmd_type            cmd;

   logic [CntW-1:0]         count_ff;
   logic [CntW-1:0]         count_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   status_type              status_ff;
   status_type              status_in;
   logic signed [DataW-1:0] removed_ff;
   logic signed [DataW-1:0] removed_in;
   logic [CountOutW-1:0]    entry_count_ff;

   logic signed [DataW-1:0] cell_value [CAPACITY];
   logic                    cell_lt    [CAPACITY];
   logic                    occupied   [CAPACITY];

   // handshake: take a request unless a response is held back
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign is_full  = (count_ff == CntW'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // command broadcast to the chain
   always_comb begin
      cmd.value   = req_value;
      cmd.insert  = req_accept && (req_op == OP_APPEND) && !is_full;
      cmd.extract = req_accept && (req_op == OP_REMOVE) && !is_empty;
   end

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                    left_lt;
      logic signed [DataW-1:0] left_value;
      logic signed [DataW-1:0] right_value;

      assign occupied[i] = (CntW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_lt    = 1'b0;
         assign left_value = cell_value[0];
      end else begin : g_body
         assign left_lt    = cell_lt[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_value = cell_value[i];
      end else begin : g_mid
         assign right_value = cell_value[i+1];
      end

      blem_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occupied[i]),
         .left_lt     (left_lt),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i]),
         .lt          (cell_lt[i])
      );
   end

   // count and response next values
   always_comb begin
      count_in   = count_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      if (cmd.insert) begin
         count_in = count_ff + CntW'(1);
      end else if (cmd.extract) begin
         count_in = count_ff - CntW'(1);
      end
      if (req_accept) begin
         removed_in = '0;
         status_in  = STATUS_OK;
         if (req_op == OP_APPEND) begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end
         end else begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               removed_in = cell_value[0];
            end
         end
      end
   end

   assign rsp_valid_in = req_accept || req_stall;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      removed_ff <= removed_in;
      if (req_accept) begin
         entry_count_ff <= CountOutW'(count_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_entry_count   = entry_count_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request without response");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      cmd.extract |=> count_ff == $past(count_ff) - CntW'(1))
      else $error("remove did not decrement count");

   a_full_no_value: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op == OP_APPEND && is_full) |=>
         (status_ff == STATUS_FULL && count_ff == CntW'(CAPACITY)))
      else $error("append on full store changed state");

   for (genvar k = 0; k < CAPACITY - 1; k++) begin : g_chk
      a_sorted: assert property (@(posedge clock) disable iff (reset)
         occupied[k+1] |-> cell_value[k] <= cell_value[k+1])
         else $error("cell chain out of order");
   end

endmodule

// File: sv/blem_cell.sv
// ----------------------------------------------------------------------------
// blem_cell: one slot of the sorted chain
// Holds one value. On insert it takes its left neighbor's value, the new
// value, or keeps its own; on extract it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module blem_cell
   import blem_pkg::*;
(
   input  logic                    clock,
   input  cell_cmd_type            cmd,
   input  logic                    occupied,
   input  logic                    left_lt,
   input  logic signed [DataW-1:0] left_value,
   input  logic signed [DataW-1:0] right_value,
   output logic signed [DataW-1:0] value,
   output logic                    lt
);

   logic signed [DataW-1:0] value_ff;
   logic signed [DataW-1:0] value_in;

   // new value belongs ahead of this slot (empty slot acts as +infinity)
   assign lt = !occupied || (cmd.value < value_ff);

   // next slot contents
   always_comb begin
      value_in = value_ff;
      if (cmd.extract) begin
         value_in = right_value;
      end else if (cmd.insert) begin
         if (left_lt) begin
            value_in = left_value;
         end else if (lt) begin
            value_in = cmd.value;
         end
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bounded extract-min unit
// Sends append and remove-smallest requests from a set of test tasks and
// predicts every response from a list of held values kept in arrival order.
// A separate process checks each response, field by field, against the
// oldest prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import blem_pkg::*;

   localparam int Capacity    = DefCapacity;
   localparam int ResetCycles = 9;
   localparam int DrainCycles = 4;
   localparam int LimitCycles = 400_000;
   localparam int RandomCount = 1500;

   // Predicted response of one request
   typedef struct {
      status_type              status;
      logic signed [DataW-1:0] removed;
      logic [CountOutW-1:0]    count;
   } result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_op = OP_APPEND;
   logic signed [DataW-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [1:0]              rsp_status;
   logic signed [DataW-1:0] rsp_removed_value;
   logic [CountOutW-1:0]    rsp_entry_count;

   // Predictor state: values held, in arrival order
   logic signed [DataW-1:0] held_values[$];
   result_type              pending_results[$];

   int fail_count  = 0;
   int cycle_count = 0;

   // Idle shaping, changed by the test tasks
   int gap_max    = 0;   // sender gap length limit, 0 = no gaps
   int burst_left = 0;
   int stall_pct  = 0;   // chance of a receiver stall run, 0 = never
   int stall_max  = 1;
   int stall_run  = 0;
   logic stall_now = 1'b0;

   bounded_list_extract_min_unit #(
      .CAPACITY (Capacity)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_count   (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LimitCycles) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver stall pattern: runs of stall or no stall of random length
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_run = $urandom_range(1, stall_max);
         stall_now = (stall_pct > 0) && ($urandom_range(1, 100) <= stall_pct);
      end else begin
         stall_run = stall_run - 1;
      end
      rsp_stall <= stall_now;
   end

   // Apply one request to the held list and return its response
   function automatic result_type predict_extract_min(input op_type op,
                                                      input logic signed [DataW-1:0] value);
      result_type r;
      int best;
      int i;
      r.status  = STATUS_OK;
      r.removed = '0;
      if (op == OP_APPEND) begin
         if (held_values.size() >= Capacity)
            r.status = STATUS_FULL;
         else
            held_values.push_back(value);
      end else if (held_values.size() == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         // strict compare keeps the earliest of equal minima
         best = 0;
         for (i = 1; i < held_values.size(); i++)
            if (held_values[i] < held_values[best])
               best = i;
         r.removed = held_values[best];
         held_values.delete(best);
      end
      r.count = CountOutW'(held_values.size());
      return r;
   endfunction

   // Response checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding: status %0d value %0d count %0d",
                   rsp_status, rsp_removed_value, rsp_entry_count);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, actual %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_removed_value !== want.removed) begin
               $error("rsp_removed_value: expected %0d, actual %0d",
                      want.removed, rsp_removed_value);
               fail_count++;
            end
            if (rsp_entry_count !== want.count) begin
               $error("rsp_entry_count: expected %0d, actual %0d",
                      want.count, rsp_entry_count);
               fail_count++;
            end
         end
      end
   end

   // Send one request; gaps fall between bursts of random length
   task automatic send_request(input op_type op, input logic signed [DataW-1:0] value);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gap_max > 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(predict_extract_min(op, value));
   endtask

   // Hold off the sender until every response is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      burst_left = 0;
   endtask

   // Mostly full-range values, some in a narrow band for duplicates, some extremes
   function automatic logic signed [DataW-1:0] random_value();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2, 3: return $signed($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_remove_when_empty();
      send_request(OP_REMOVE, 32'sh1234_5678);
      wait_for_drain();
   endtask

   task automatic test_fill_with_extremes();
      send_request(OP_APPEND, 32'sh7FFF_FFFF);
      send_request(OP_APPEND, 32'sh8000_0000);
      send_request(OP_APPEND, 0);
      send_request(OP_APPEND, -1);
      send_request(OP_APPEND, 1);
      send_request(OP_APPEND, -7);
      send_request(OP_APPEND, 5);
      send_request(OP_APPEND, -7);
      send_request(OP_APPEND, 32'sh5555_5555);
      send_request(OP_APPEND, 32'shAAAA_AAAA);
      send_request(OP_APPEND, 32'sh8000_0000);
      send_request(OP_APPEND, -100);
      send_request(OP_APPEND, 5);
      send_request(OP_APPEND, 100);
      send_request(OP_APPEND, 32'sh7FFF_FFFF);
      send_request(OP_APPEND, 3);
      wait_for_drain();
   endtask

   // Store full: the append is dropped
   task automatic test_append_when_full();
      send_request(OP_APPEND, 42);
      wait_for_drain();
   endtask

   // Smallest first, with equal minima taken one at a time
   task automatic test_remove_order();
      repeat (5) send_request(OP_REMOVE, $urandom);
      wait_for_drain();
   endtask

   // Random mix in phases that lean toward append, toward remove or neither, so the store
   // swings between full and empty; idle settings change after every fifth phase
   task automatic test_random_mix();
      int sent;
      int phase_len;
      int append_pct;
      int phase;
      sent  = 0;
      phase = 0;
      while (sent < RandomCount) begin
         case (phase % 3)
            0: append_pct = 80;
            1: append_pct = 20;
            default: append_pct = 50;
         endcase
         phase_len = $urandom_range(20, 80);
         repeat (phase_len) begin
            if ($urandom_range(1, 100) <= append_pct)
               send_request(OP_APPEND, random_value());
            else
               send_request(OP_REMOVE, random_value());
            sent++;
         end
         phase++;
         if (phase % 5 == 0) begin
            wait_for_drain();
            case ($urandom_range(0, 3))
               0: begin gap_max = 0; stall_pct = 0;  stall_max = 1;  end
               1: begin gap_max = 3; stall_pct = 30; stall_max = 4;  end
               2: begin gap_max = 8; stall_pct = 50; stall_max = 12; end
               default: begin gap_max = 0; stall_pct = 70; stall_max = 2; end
            endcase
         end
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      gap_max   = 2;
      stall_pct = 30;
      stall_max = 3;
      test_remove_when_empty();
      test_fill_with_extremes();
      test_append_when_full();
      test_remove_order();
      test_random_mix();

      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: bounded_list_extract_min_unit.f
sv/blem_pkg.sv
sv/blem_cell.sv
sv/bounded_list_extract_min_unit.sv
test/tb.sv
